>>> design/iir3_pkg.sv
// Shared types, constants and microcode ROM for the third-order IIR filter.
package iir3_pkg;

    // Fixed formats: coefficients Q2.16, delay words Q24.8
    localparam int COEF_W    = 18;
    localparam int STATE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_FRAC = 16;
    localparam int STATE_FRAC = 8;
    localparam int PROD_FRAC = COEF_FRAC + STATE_FRAC;
    localparam int PROD_W    = COEF_W + STATE_W;
    // worst case is four full-scale products plus guard
    localparam int ACC_W     = PROD_W + 2;

    localparam int NUM_REGS  = 7;
    localparam int IDX_W     = 3;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_FF0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_FF1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_FF2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_FF3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_FB1 = 3'd4;
    localparam logic [IDX_W-1:0] REG_FB2 = 3'd5;
    localparam logic [IDX_W-1:0] REG_FB3 = 3'd6;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [STATE_W-1:0] t_state;

    localparam t_coef COEF_RST [NUM_REGS] = '{
        18'sd1094, 18'sd3283, 18'sd3283, 18'sd1094,
        -18'sd117834, 18'sd80020, -18'sd18992
    };

    // 200.0 in Q24.8
    localparam t_state DLY_RST = 32'sd51200;

    // microcode field codes
    localparam int PC_W = 4;

    localparam logic [1:0] BR_SEQ      = 2'd0;
    localparam logic [1:0] BR_WAIT_IN  = 2'd1;
    localparam logic [1:0] BR_WAIT_OUT = 2'd2;

    localparam logic [1:0] WSEL_W1   = 2'd0;
    localparam logic [1:0] WSEL_W2   = 2'd1;
    localparam logic [1:0] WSEL_W3   = 2'd2;
    localparam logic [1:0] WSEL_WNEW = 2'd3;

    localparam logic [2:0] ACC_NOP   = 3'd0;
    localparam logic [2:0] ACC_LOADS = 3'd1;
    localparam logic [2:0] ACC_SUB   = 3'd2;
    localparam logic [2:0] ACC_ADD   = 3'd3;
    localparam logic [2:0] ACC_LOADP = 3'd4;

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;

    typedef struct packed {
        logic [1:0]       br;
        logic [PC_W-1:0]  tgt;
        logic [IDX_W-1:0] csel;
        logic [1:0]       wsel;
        logic [2:0]       acc_op;
        logic             w_upd;
        logic             out_upd;
    } t_uc_word;

    // Product issued in step k is consumed by the accumulator in step k+1.
    function automatic t_uc_word uc_rom(input logic [PC_W-1:0] pc);
        t_uc_word uw;
        uw = '{br: BR_SEQ, tgt: PC_IDLE, csel: REG_FF0, wsel: WSEL_W1,
               acc_op: ACC_NOP, w_upd: 1'b0, out_upd: 1'b0};
        case (pc)
            4'd0: begin
                uw.br = BR_WAIT_IN; uw.csel = REG_FB1; uw.wsel = WSEL_W1;
                uw.acc_op = ACC_LOADS;
            end
            4'd1: begin
                uw.csel = REG_FB2; uw.wsel = WSEL_W2; uw.acc_op = ACC_SUB;
            end
            4'd2: begin
                uw.csel = REG_FB3; uw.wsel = WSEL_W3; uw.acc_op = ACC_SUB;
            end
            4'd3: begin
                uw.acc_op = ACC_SUB;
            end
            4'd4: begin
                uw.csel = REG_FF1; uw.wsel = WSEL_W1; uw.w_upd = 1'b1;
            end
            4'd5: begin
                uw.csel = REG_FF0; uw.wsel = WSEL_WNEW; uw.acc_op = ACC_LOADP;
            end
            4'd6: begin
                uw.csel = REG_FF2; uw.wsel = WSEL_W2; uw.acc_op = ACC_ADD;
            end
            4'd7: begin
                uw.csel = REG_FF3; uw.wsel = WSEL_W3; uw.acc_op = ACC_ADD;
            end
            4'd8: begin
                uw.acc_op = ACC_ADD;
            end
            4'd9: begin
                uw.br = BR_WAIT_OUT; uw.tgt = PC_IDLE; uw.out_upd = 1'b1;
            end
            default: begin
                uw.br = BR_WAIT_OUT; uw.tgt = PC_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

>>> design/third_order_iir_filter_unit.sv
// Third-order direct form II IIR filter: microcoded sequencer around one MAC.
// An input beat runs the feedback and feedforward products, then the result
// write, which waits while the output slot is full. The next beat is taken
// only at idle: the seven products go one at a time through the single 18x32
// multiplier and its accumulator. Reset (synchronous, active low): coefficients
// to defaults, delay line to 200.0, sequencer idle, output empty.
module third_order_iir_filter_unit
    import iir3_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_clamped,
    input  logic                       i_cfg_we,
    input  logic [IDX_W-1:0]           i_cfg_idx,
    input  logic [COEF_W-1:0]          i_cfg_wdata
);

    localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) <<< (PROD_FRAC - 1);
    localparam logic signed [ACC_W-1:0] W_MAX  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] W_MIN  = ACC_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN  = ACC_W'(-32768);

    logic [PC_W-1:0]          r_pc, n_pc;
    t_coef                    r_coef [NUM_REGS];
    t_state                   r_dly  [3];
    t_state                   r_wnew;
    logic                     r_hit;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                     r_out_clamped;

    t_uc_word                 uw;
    logic                     in_beat;
    logic                     out_free;
    t_coef                    mul_c;
    t_state                   mul_w;
    logic signed [ACC_W-1:0]  w_rnd, w_sh, y_rnd, y_sh;
    t_state                   w_sat;
    logic                     w_clip;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                     y_clip;

    assign uw         = uc_rom(r_pc);
    assign o_in_ready = i_rst_n && (r_pc == PC_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // operand selection for the shared multiplier
    always_comb begin
        mul_c = r_coef[uw.csel];
        case (uw.wsel)
            WSEL_W1:   mul_w = r_dly[0];
            WSEL_W2:   mul_w = r_dly[1];
            WSEL_W3:   mul_w = r_dly[2];
            WSEL_WNEW: mul_w = r_wnew;
            default:   mul_w = r_dly[0];
        endcase
    end

    always_comb begin
        case (uw.acc_op)
            ACC_LOADS: n_acc = ACC_W'(i_sample_in) <<< PROD_FRAC;
            ACC_SUB:   n_acc = r_acc - ACC_W'(r_prod);
            ACC_ADD:   n_acc = r_acc + ACC_W'(r_prod);
            ACC_LOADP: n_acc = ACC_W'(r_prod);
            default:   n_acc = r_acc;
        endcase
    end

    // new delay word: round half up, then saturate to 32 bits
    always_comb begin
        w_rnd  = r_acc + HALF_W;
        w_sh   = w_rnd >>> COEF_FRAC;
        w_clip = 1'b1;
        if (w_sh > W_MAX) begin
            w_sat = W_MAX[STATE_W-1:0];
        end else if (w_sh < W_MIN) begin
            w_sat = W_MIN[STATE_W-1:0];
        end else begin
            w_sat  = w_sh[STATE_W-1:0];
            w_clip = 1'b0;
        end
    end

    always_comb begin
        y_rnd  = r_acc + HALF_Y;
        y_sh   = y_rnd >>> PROD_FRAC;
        y_clip = 1'b1;
        if (y_sh > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_W-1:0];
        end else if (y_sh < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_W-1:0];
        end else begin
            y_sat  = y_sh[SAMPLE_W-1:0];
            y_clip = 1'b0;
        end
    end

    always_comb begin
        case (uw.br)
            BR_WAIT_IN:  n_pc = in_beat ? r_pc + 1'b1 : r_pc;
            BR_WAIT_OUT: n_pc = out_free ? uw.tgt : r_pc;
            default:     n_pc = r_pc + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= COEF_RST[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_dly[i] <= DLY_RST;
            end
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we && (i_cfg_idx <= REG_FB3)) begin
                r_coef[i_cfg_idx] <= t_coef'(i_cfg_wdata);
            end
            if (uw.w_upd) begin
                r_hit <= w_clip;
            end
            if (uw.out_upd && out_free) begin
                r_out_valid <= 1'b1;
                r_dly[2]    <= r_dly[1];
                r_dly[1]    <= r_dly[0];
                r_dly[0]    <= r_wnew;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_prod <= mul_c * mul_w;
        r_acc  <= n_acc;
        if (uw.w_upd) begin
            r_wnew <= w_sat;
        end
        if (uw.out_upd && out_free) begin
            r_out_sample  <= y_sat;
            r_out_clamped <= r_hit | y_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clamped    = r_out_clamped;

endmodule

>>> design/iir3_checker.sv
// Port-level checker for the third-order IIR filter, bound to the top level.
module iir3_checker
    import iir3_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] o_sample_out,
    input logic                       o_clamped
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // a beat starts the program, so the input side closes at once
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready ##1 !o_in_ready)
        else $error("input ready while an item is in flight");

    // a new result only appears at the end of a program run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result raised with the sequencer idle");

    // an input beat is never directly followed by a rising result
    a_result_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(in_beat))
        else $error("result raised right after an input beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sample_out) && $stable(o_clamped))
        else $error("stalled result changed or dropped");

endmodule

bind third_order_iir_filter_unit iir3_checker u_iir3_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out),
    .o_clamped    (o_clamped)
);
